FILE: design/rbl_pkg.sv
`default_nettype none

package rbl_pkg;

    localparam int RING_FRAMES   = 16384;
    localparam int SAMPLE_BITS   = 24;
    localparam int FRACTION_BITS = 16;

    localparam int RING_AW    = $clog2(RING_FRAMES);
    localparam int BANK_AW    = RING_AW - 1;
    localparam int BANK_DEPTH = RING_FRAMES / 2;

    localparam int POS_BITS      = 48;
    localparam int STEP_BITS     = 20;
    localparam int LAG_BITS      = 14;
    localparam int CFG_DATA_BITS = STEP_BITS;
    localparam int SUM_BITS      = STEP_BITS + 1;
    localparam int DIFF_BITS     = SAMPLE_BITS + 1;
    localparam int PROD_BITS     = DIFF_BITS + FRACTION_BITS + 1;
    localparam int ROUND_BIAS    = 1 << (FRACTION_BITS - 1);

    localparam logic [STEP_BITS-1:0] RATE_STEP_RESET = STEP_BITS'(65536);
    localparam logic [LAG_BITS-1:0]  MAX_LAG_RESET   = LAG_BITS'(12000);

    typedef enum logic [1:0] {
        ACT_WRITE     = 2'd0,
        ACT_LAG_CHECK = 2'd1,
        ACT_READ      = 2'd2,
        ACT_RESYNC    = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        REG_RATE_STEP = 2'd0,
        REG_MAX_LAG   = 2'd1,
        REG_MONO      = 2'd2
    } cfg_reg_t;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    typedef struct packed {
        sample_t left;
        sample_t right;
    } frame_t;

    typedef struct packed {
        logic               wr_en;
        logic [RING_AW-1:0] wr_slot;
        logic               rd_en;
        logic [RING_AW-1:0] rd_slot;
    } ring_req_t;

    typedef struct packed {
        logic                     valid;
        logic                     underrun;
        logic [FRACTION_BITS-1:0] frac;
        logic                     mono;
    } issue_t;

endpackage

`default_nettype wire

FILE: design/rbl_if.sv
`default_nettype none

interface rbl_cmd_if;
    logic                   valid;
    logic                   ready;
    rbl_pkg::action_t       action;
    rbl_pkg::sample_t       left_in;
    rbl_pkg::sample_t       right_in;

    modport source (output valid, action, left_in, right_in, input ready);
    modport sink   (input valid, action, left_in, right_in, output ready);
endinterface

interface rbl_result_if;
    logic                   valid;
    logic                   ready;
    rbl_pkg::sample_t       left_out;
    rbl_pkg::sample_t       right_out;
    logic                   underrun;

    modport source (output valid, left_out, right_out, underrun, input ready);
    modport sink   (input valid, left_out, right_out, underrun, output ready);
endinterface

interface rbl_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          index;
    logic [rbl_pkg::CFG_DATA_BITS-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: design/rbl_ring.sv
`default_nettype none

// Frame store split into an even and an odd bank, so the two neighboring
// frames needed by one read item come out of the memories in the same cycle.
module rbl_ring (
    input  wire logic               clk,
    input  wire rbl_pkg::ring_req_t req,
    input  wire rbl_pkg::frame_t    wr_frame,
    output rbl_pkg::frame_t         frame_a,
    output rbl_pkg::frame_t         frame_b
);

    rbl_pkg::frame_t bank_even [rbl_pkg::BANK_DEPTH];
    rbl_pkg::frame_t bank_odd  [rbl_pkg::BANK_DEPTH];

    rbl_pkg::frame_t even_q_reg;
    rbl_pkg::frame_t odd_q_reg;
    logic            swap_reg;

    logic [rbl_pkg::BANK_AW-1:0] wr_addr;
    logic [rbl_pkg::BANK_AW-1:0] rd_addr_odd;
    logic [rbl_pkg::BANK_AW-1:0] rd_addr_even;

    assign wr_addr     = req.wr_slot[rbl_pkg::RING_AW-1:1];
    assign rd_addr_odd = req.rd_slot[rbl_pkg::RING_AW-1:1];
    // When the first frame sits in the odd bank, its successor is the next even row.
    assign rd_addr_even = req.rd_slot[0] ? rd_addr_odd + rbl_pkg::BANK_AW'(1) : rd_addr_odd;

    always_ff @(posedge clk)
    begin
        if (req.wr_en && !req.wr_slot[0])
        begin
            bank_even[wr_addr] <= wr_frame;
        end
        if (req.wr_en && req.wr_slot[0])
        begin
            bank_odd[wr_addr] <= wr_frame;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            even_q_reg <= bank_even[rd_addr_even];
            odd_q_reg  <= bank_odd[rd_addr_odd];
            swap_reg   <= req.rd_slot[0];
        end
    end

    assign frame_a = swap_reg ? odd_q_reg : even_q_reg;
    assign frame_b = swap_reg ? even_q_reg : odd_q_reg;

endmodule

`default_nettype wire

FILE: design/rbl_pos.sv
`default_nettype none

// Writer and reader positions plus the configuration registers. Items update
// positions when accepted, save in-limit lag checks and underrun reads.
module rbl_pos (
    input  wire logic             clk,
    input  wire logic             rst_n,
    rbl_cfg_if.sink               cfg,
    input  wire logic             accept,
    input  wire rbl_pkg::action_t action,
    output rbl_pkg::ring_req_t    ring_req,
    output rbl_pkg::issue_t       issue
);

    logic [rbl_pkg::STEP_BITS-1:0]     rate_step_reg;
    logic [rbl_pkg::LAG_BITS-1:0]      max_lag_reg;
    logic                              mono_reg;

    logic [rbl_pkg::POS_BITS-1:0]      fw_reg, fw_next;
    logic [rbl_pkg::POS_BITS-1:0]      rw_reg, rw_next;
    logic [rbl_pkg::FRACTION_BITS-1:0] frac_reg, frac_next;

    logic [rbl_pkg::POS_BITS-1:0]      gap;
    logic [rbl_pkg::POS_BITS-1:0]      lag_target;
    logic                              ahead_ok;
    logic                              lag_excess;
    logic [rbl_pkg::SUM_BITS-1:0]      step_sum;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_step_reg <= rbl_pkg::RATE_STEP_RESET;
            max_lag_reg   <= rbl_pkg::MAX_LAG_RESET;
            mono_reg      <= 1'b0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                rbl_pkg::REG_RATE_STEP: rate_step_reg <= cfg.data[rbl_pkg::STEP_BITS-1:0];
                rbl_pkg::REG_MAX_LAG:   max_lag_reg   <= cfg.data[rbl_pkg::LAG_BITS-1:0];
                rbl_pkg::REG_MONO:      mono_reg      <= cfg.data[0];
                default:                ;
            endcase
        end
    end

    // Writer minus reader, read as a signed distance.
    assign gap        = fw_reg - rw_reg;
    assign ahead_ok   = !gap[rbl_pkg::POS_BITS-1] && (gap[rbl_pkg::POS_BITS-1:1] != '0);
    assign lag_excess = !gap[rbl_pkg::POS_BITS-1]
                        && (gap > rbl_pkg::POS_BITS'(max_lag_reg));
    assign lag_target = fw_reg - rbl_pkg::POS_BITS'(max_lag_reg);
    assign step_sum   = rbl_pkg::SUM_BITS'(frac_reg) + rbl_pkg::SUM_BITS'(rate_step_reg);

    always_comb
    begin
        fw_next   = fw_reg;
        rw_next   = rw_reg;
        frac_next = frac_reg;
        if (accept)
        begin
            unique case (action)
                rbl_pkg::ACT_WRITE:
                begin
                    fw_next = fw_reg + rbl_pkg::POS_BITS'(1);
                end
                rbl_pkg::ACT_LAG_CHECK:
                begin
                    if (lag_excess)
                    begin
                        rw_next   = lag_target;
                        frac_next = '0;
                    end
                end
                rbl_pkg::ACT_READ:
                begin
                    if (ahead_ok)
                    begin
                        rw_next   = rw_reg + rbl_pkg::POS_BITS'(
                                    step_sum[rbl_pkg::SUM_BITS-1:rbl_pkg::FRACTION_BITS]);
                        frac_next = step_sum[rbl_pkg::FRACTION_BITS-1:0];
                    end
                end
                rbl_pkg::ACT_RESYNC:
                begin
                    rw_next   = fw_reg;
                    frac_next = '0;
                end
                default:
                begin
                    rw_next = rw_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg   <= '0;
            rw_reg   <= '0;
            frac_reg <= '0;
        end
        else
        begin
            fw_reg   <= fw_next;
            rw_reg   <= rw_next;
            frac_reg <= frac_next;
        end
    end

    assign ring_req.wr_en   = accept && (action == rbl_pkg::ACT_WRITE);
    assign ring_req.wr_slot = fw_reg[rbl_pkg::RING_AW-1:0];
    assign ring_req.rd_en   = accept && (action == rbl_pkg::ACT_READ);
    assign ring_req.rd_slot = rw_reg[rbl_pkg::RING_AW-1:0];

    assign issue.valid    = ring_req.rd_en;
    assign issue.underrun = !ahead_ok;
    assign issue.frac     = frac_reg;
    assign issue.mono     = mono_reg;

    a_resync_lands: assert property (@(posedge clk) disable iff (!rst_n)
        accept && action == rbl_pkg::ACT_RESYNC |=> rw_reg == fw_reg && frac_reg == '0)
        else $error("reader not on writer after resync");

    a_lag_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        accept && action == rbl_pkg::ACT_LAG_CHECK
        |=> gap[rbl_pkg::POS_BITS-1] || gap <= rbl_pkg::POS_BITS'(max_lag_reg))
        else $error("reader still beyond lag limit after lag check");

    a_underrun_holds: assert property (@(posedge clk) disable iff (!rst_n)
        accept && action == rbl_pkg::ACT_READ && !ahead_ok
        |=> $stable(rw_reg) && $stable(frac_reg))
        else $error("reader moved on an underrun");

endmodule

`default_nettype wire

FILE: design/rbl_interp.sv
`default_nettype none

// Two-stage interpolation pipeline behind the ring read, ending in the
// output register. Stage 1 multiplies the frame difference by the fraction,
// stage 2 rounds and adds the first sample.
module rbl_interp (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire rbl_pkg::issue_t issue,
    input  wire rbl_pkg::frame_t frame_a,
    input  wire rbl_pkg::frame_t frame_b,
    output logic                 take,
    rbl_result_if.source         result
);

    logic                                   s1_valid_reg, s1_valid_next;
    rbl_pkg::issue_t                        s1_meta_reg;

    logic                                   s2_valid_reg, s2_valid_next;
    logic                                   s2_under_reg;
    logic                                   s2_mono_reg;
    logic signed [rbl_pkg::PROD_BITS-1:0]   s2_prod_l_reg, s2_prod_r_reg;
    rbl_pkg::sample_t                       s2_a_l_reg, s2_a_r_reg;

    logic                                   out_valid_reg, out_valid_next;
    rbl_pkg::sample_t                       out_left_reg, out_right_reg;
    logic                                   out_under_reg;

    logic                                   out_free, s2_free;
    logic signed [rbl_pkg::DIFF_BITS-1:0]   diff_l, diff_r;
    logic signed [rbl_pkg::FRACTION_BITS:0] frac_s;
    logic signed [rbl_pkg::PROD_BITS-1:0]   prod_l, prod_r;
    logic signed [rbl_pkg::PROD_BITS-1:0]   rnd_l, rnd_r;
    logic signed [rbl_pkg::PROD_BITS-1:0]   q_l, q_r;
    rbl_pkg::sample_t                       lerp_l, lerp_r;

    assign out_free = !out_valid_reg || result.ready;
    assign s2_free  = !s2_valid_reg || out_free;
    assign take     = !s1_valid_reg || s2_free;

    assign diff_l = rbl_pkg::DIFF_BITS'(frame_b.left) - rbl_pkg::DIFF_BITS'(frame_a.left);
    assign diff_r = rbl_pkg::DIFF_BITS'(frame_b.right) - rbl_pkg::DIFF_BITS'(frame_a.right);
    assign frac_s = $signed({1'b0, s1_meta_reg.frac});
    assign prod_l = diff_l * frac_s;
    assign prod_r = diff_r * frac_s;

    // The arithmetic shift floors, so the bias turns it into round-half-up.
    assign rnd_l  = s2_prod_l_reg + rbl_pkg::PROD_BITS'(rbl_pkg::ROUND_BIAS);
    assign rnd_r  = s2_prod_r_reg + rbl_pkg::PROD_BITS'(rbl_pkg::ROUND_BIAS);
    assign q_l    = rnd_l >>> rbl_pkg::FRACTION_BITS;
    assign q_r    = rnd_r >>> rbl_pkg::FRACTION_BITS;
    assign lerp_l = s2_a_l_reg + q_l[rbl_pkg::SAMPLE_BITS-1:0];
    assign lerp_r = s2_a_r_reg + q_r[rbl_pkg::SAMPLE_BITS-1:0];

    assign s1_valid_next  = issue.valid || (s1_valid_reg && !s2_free);
    assign s2_valid_next  = (s1_valid_reg && s2_free) || (s2_valid_reg && !out_free);
    assign out_valid_next = (s2_valid_reg && out_free) || (out_valid_reg && !result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue.valid)
        begin
            s1_meta_reg <= issue;
        end
        if (s1_valid_reg && s2_free)
        begin
            s2_under_reg  <= s1_meta_reg.underrun;
            s2_mono_reg   <= s1_meta_reg.mono;
            s2_prod_l_reg <= prod_l;
            s2_prod_r_reg <= prod_r;
            s2_a_l_reg    <= frame_a.left;
            s2_a_r_reg    <= frame_a.right;
        end
        if (s2_valid_reg && out_free)
        begin
            out_under_reg <= s2_under_reg;
            out_left_reg  <= s2_under_reg ? '0 : lerp_l;
            if (s2_under_reg)
            begin
                out_right_reg <= '0;
            end
            else
            begin
                out_right_reg <= s2_mono_reg ? lerp_l : lerp_r;
            end
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.left_out  = out_left_reg;
    assign result.right_out = out_right_reg;
    assign result.underrun  = out_under_reg;

    a_ring_data_held: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s2_free |=> $stable(frame_a) && $stable(frame_b))
        else $error("ring read data changed under a stalled item");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result.ready
        |=> out_valid_reg && $stable(out_left_reg) && $stable(out_right_reg)
            && $stable(out_under_reg))
        else $error("result item changed while the receiver stalled");

    a_underrun_silent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_under_reg |-> out_left_reg == '0 && out_right_reg == '0)
        else $error("underrun item carries nonzero samples");

endmodule

`default_nettype wire

FILE: design/ring_buffer_linear_resampler.sv
`default_nettype none

// Stereo frame ring with a fractional reader and linear interpolation.
// cmd carries one item per handshake: write a frame, lag check, read, or
// resync. Every read item yields exactly one item on result, in order;
// the other actions yield none. cfg writes rate_step (index 0),
// max_lag_frames (index 1) and mono_source (index 2) and is always ready;
// write it only while no read result is outstanding.
// A read item passes the ring read registers, the multiply stage and the
// output register (round and add) before its result shows on result.
// Throughput: one item per cycle on cmd unless result stalls. Both neighboring
// frames come from the even and odd ring banks in a single read cycle.
// When result stalls, the pipeline holds its items; cmd.ready drops once the
// ring read stage, the multiply stage and the output register are all full.
// Reset restores the register defaults, zeroes the writer and reader
// positions and empties the pipeline. The ring is not cleared; the position
// check keeps unwritten frames out of the results.
module ring_buffer_linear_resampler (
    input  wire logic    clk,
    input  wire logic    rst_n,
    rbl_cfg_if.sink      cfg,
    rbl_cmd_if.sink      cmd,
    rbl_result_if.source result
);

    logic               accept;
    logic               take;
    rbl_pkg::ring_req_t ring_req;
    rbl_pkg::issue_t    issue;
    rbl_pkg::frame_t    wr_frame;
    rbl_pkg::frame_t    frame_a;
    rbl_pkg::frame_t    frame_b;

    assign cmd.ready = take;
    assign accept    = cmd.valid && take;

    assign wr_frame.left  = cmd.left_in;
    assign wr_frame.right = cmd.right_in;

    rbl_pos u_pos (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .accept   (accept),
        .action   (cmd.action),
        .ring_req (ring_req),
        .issue    (issue)
    );

    rbl_ring u_ring (
        .clk      (clk),
        .req      (ring_req),
        .wr_frame (wr_frame),
        .frame_a  (frame_a),
        .frame_b  (frame_b)
    );

    rbl_interp u_interp (
        .clk     (clk),
        .rst_n   (rst_n),
        .issue   (issue),
        .frame_a (frame_a),
        .frame_b (frame_b),
        .take    (take),
        .result  (result)
    );

endmodule

`default_nettype wire
